// ----- design/word_tokenizer_fnv1a_hasher_assert.svh -----
// Assertion macros for the word tokenizer and FNV-1a hasher.
// Used by the top level and wtf_word_core; they expect clk and rst in scope.
`ifndef WORD_TOKENIZER_FNV1A_HASHER_ASSERT_SVH
`define WORD_TOKENIZER_FNV1A_HASHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WTF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wtf_pkg.sv -----
// Shared types and constants for the word tokenizer and FNV-1a hasher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wtf_pkg;

  localparam int HASH_W = 64;
  localparam int LEN_W  = 16;
  localparam int BYTE_W = 8;

  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT = 16'd65535;

  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_APOS    = 8'h27;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

  typedef struct packed {
    logic              emit;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  length;
  } word_result_t;

  // Folds A-Z to lowercase; every other byte passes unchanged.
  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// ----- design/word_tokenizer_fnv1a_hasher.sv -----
// Top level of the word tokenizer with 64-bit FNV-1a word hashing.
// Depends on wtf_pkg, wtf_word_core and the assertion macro header.
`timescale 1ns / 1ps
`include "word_tokenizer_fnv1a_hasher_assert.svh"

// The block takes one text byte per transfer on the slave stream and
// returns one word per finished text word on the master stream: the FNV-1a
// 64 hash of the lowercased word bytes and its length, saturating at 65535.
// A word starts on a letter and runs through letters and apostrophes;
// s_tlast marks the last byte of a passage and closes any open word. It
// accepts one byte every clock cycle while s_tready is high. A byte is held
// in the input register, and the combinational hash update (xor plus
// shift-add multiply by the prime) then loads the result register, which
// drives the master stream. s_tready drops only while the input register is
// full and the result register holds a word that m_tready has not yet taken.
module word_tokenizer_fnv1a_hasher
  import wtf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [BYTE_W-1:0]       s_tdata,   // [7:0] text_byte
  input  logic                    s_tlast,   // passage_end
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [HASH_W+LEN_W-1:0] m_tdata    // [63:0] word_hash, [79:64] word_length
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              step;
  word_result_t      res;
  logic              out_valid;
  logic [HASH_W-1:0] out_hash;
  logic [LEN_W-1:0]  out_len;

  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  wtf_word_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .text_byte (in_byte),
    .last      (in_last),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_hash <= res.hash;
      out_len  <= res.length;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_hash};

  `WTF_ASSERT_IMPL(a_len_nonzero, m_tvalid, m_tdata[HASH_W+LEN_W-1:HASH_W] != '0,
                   "word of zero length")
  `WTF_ASSERT_NEXT(a_emit_lands, step && res.emit, m_tvalid, "emitted word not presented")
  `WTF_ASSERT_NEXT(a_byte_kept, in_valid && !step, in_valid, "stalled byte dropped")

endmodule

// ----- design/wtf_fnv_step.sv -----
// One FNV-1a round: xor in a byte, multiply by the 64-bit FNV prime.
// Depends on wtf_pkg for widths.
`timescale 1ns / 1ps

module wtf_fnv_step
  import wtf_pkg::*;
(
  input  logic [HASH_W-1:0] hash_in,
  input  logic [BYTE_W-1:0] ch,
  output logic [HASH_W-1:0] hash_out
);

  logic [HASH_W-1:0] x;

  assign x = hash_in ^ {{(HASH_W-BYTE_W){1'b0}}, ch};

  // The prime is 2^40 + 0x1b3, so the product modulo 2^64 is a sparse
  // sum of shifted copies: bits 40, 8, 7, 5, 4, 1 and 0.
  assign hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                  + (x << 4) + (x << 1) + x;

endmodule

// ----- design/wtf_word_core.sv -----
// Word state (running hash, length, in-word flag) and the per-byte step.
// Depends on wtf_pkg, wtf_fnv_step and the assertion macro header.
`timescale 1ns / 1ps
`include "word_tokenizer_fnv1a_hasher_assert.svh"

module wtf_word_core
  import wtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              last,
  output word_result_t      res
);

  logic [HASH_W-1:0] hash_accum;
  logic [LEN_W-1:0]  length_count;
  logic              inside_word;

  logic [BYTE_W-1:0] ch;
  logic              letter;
  logic              word_byte;
  logic [HASH_W-1:0] hash_upd;
  logic [HASH_W-1:0] hash_next;
  logic [LEN_W-1:0]  length_next;
  logic              inside_next;

  assign ch        = fold_case(text_byte);
  assign letter    = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z);
  // An apostrophe only continues a word that is already open.
  assign word_byte = letter || (inside_word && ch == CH_APOS);

  wtf_fnv_step u_fnv (
    .hash_in  (hash_accum),
    .ch       (ch),
    .hash_out (hash_upd)
  );

  always_comb begin
    hash_next   = hash_accum;
    length_next = length_count;
    inside_next = inside_word;
    if (word_byte) begin
      hash_next   = hash_upd;
      inside_next = 1'b1;
      if (length_count < LENGTH_LIMIT) begin
        length_next = length_count + 1'b1;
      end
    end
  end

  assign res.emit   = inside_next && (!word_byte || last);
  assign res.hash   = hash_next;
  assign res.length = length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_accum   <= FNV_BASIS;
      length_count <= '0;
      inside_word  <= 1'b0;
    end else if (step) begin
      if (res.emit || last) begin
        hash_accum   <= FNV_BASIS;
        length_count <= '0;
        inside_word  <= 1'b0;
      end else begin
        hash_accum   <= hash_next;
        length_count <= length_next;
        inside_word  <= inside_next;
      end
    end
  end

  `WTF_ASSERT_IMPL(a_len_in_range, 1'b1, length_count <= LENGTH_LIMIT, "length above limit")
  `WTF_ASSERT_IMPL(a_idle_is_clear, !inside_word,
                   length_count == '0 && hash_accum == FNV_BASIS, "stale state outside word")
  `WTF_ASSERT_NEXT(a_last_closes, step && last, !inside_word, "word open after last byte")

endmodule
